// File: sv/assert_macros.svh
// Assertion macros used by the selector controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising clock edge outside reset
`define PSEL_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition that must hold at every rising clock edge outside reset
`define PSEL_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   `PSEL_ASSERT(label, clk, rst, (1'b1 |-> (cond)), msg)

`endif

// File: sv/psel_pkg.sv
// Shared widths, codes and the store access struct of the partial shuffle selector
package psel_pkg;

   localparam int TOTAL_W = 11;
   localparam int IDX_W = 10;
   localparam int VAL_W = 10;
   localparam int STATUS_W = 3;
   localparam int ADDR_FULL_W = 11;
   localparam int CAPACITY_DEFAULT = 1024;
   localparam int DEPTH_MAX = 2048;

   localparam logic REQ_START = 1'b0;
   localparam logic REQ_PICK = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK = 3'd0;
   localparam logic [STATUS_W-1:0] ST_SEL_OVER = 3'd1;
   localparam logic [STATUS_W-1:0] ST_CAP_OVER = 3'd2;
   localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 3'd3;
   localparam logic [STATUS_W-1:0] ST_IDLE = 3'd4;

   typedef struct packed {
      logic rd_en;
      logic [ADDR_FULL_W-1:0] rd_addr_a;
      logic [ADDR_FULL_W-1:0] rd_addr_b;
      logic wr_en;
      logic [ADDR_FULL_W-1:0] wr_addr;
      logic [VAL_W-1:0] wr_data;
   } psel_mem_req_type;

endpackage

// File: sv/psel_store.sv
// Permutation store: two registered read ports, one write port
module psel_store
   import psel_pkg::*;
#(
   parameter int DEPTH = CAPACITY_DEFAULT,
   parameter int ADDR_W = $clog2(CAPACITY_DEFAULT)
) (
   input  logic clock,
   input  psel_mem_req_type mem_req,
   output logic [VAL_W-1:0] rd_data_a,
   output logic [VAL_W-1:0] rd_data_b
);

   logic [VAL_W-1:0] store_mem [DEPTH];
   logic [VAL_W-1:0] rd_a_ff;
   logic [VAL_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         store_mem[mem_req.wr_addr[ADDR_W-1:0]] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_a_ff <= store_mem[mem_req.rd_addr_a[ADDR_W-1:0]];
         rd_b_ff <= store_mem[mem_req.rd_addr_b[ADDR_W-1:0]];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// File: sv/psel_ctrl.sv
// Selection sequencer: request checks, refill walk, swap steps and result register
`include "assert_macros.svh"

module psel_ctrl
   import psel_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic req_type,
   input  logic [TOTAL_W-1:0] req_total,
   input  logic [TOTAL_W-1:0] req_select_count,
   input  logic [IDX_W-1:0] req_pick_index,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [VAL_W-1:0] rsp_picked_value,
   output logic [IDX_W-1:0] rsp_position,
   output logic rsp_last,
   output logic [STATUS_W-1:0] rsp_status,
   output psel_mem_req_type mem_req,
   input  logic [VAL_W-1:0] rd_data_a,
   input  logic [VAL_W-1:0] rd_data_b
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_FILL = 2'd1;
   localparam logic [1:0] S_SWAP_A = 2'd2;
   localparam logic [1:0] S_SWAP_B = 2'd3;
   localparam logic [16:0] CapLimit = 17'(CAPACITY);

   logic [1:0] state_ff, state_in;
   logic [TOTAL_W-1:0] prev_total_ff, prev_total_in;
   logic [TOTAL_W-1:0] act_total_ff, act_total_in;
   logic [TOTAL_W-1:0] act_select_ff, act_select_in;
   logic [TOTAL_W-1:0] cur_pos_ff, cur_pos_in;
   logic sel_active_ff, sel_active_in;
   logic [TOTAL_W-1:0] fill_cnt_ff, fill_cnt_in;
   logic [IDX_W-1:0] pick_idx_ff, pick_idx_in;
   logic [IDX_W-1:0] pick_pos_ff, pick_pos_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0] rsp_value_ff, rsp_value_in;
   logic [IDX_W-1:0] rsp_pos_ff, rsp_pos_in;
   logic rsp_last_ff, rsp_last_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic out_free;
   logic accept;
   logic load;
   logic [TOTAL_W-1:0] next_pos;
   logic [TOTAL_W-1:0] fill_next;
   logic [TOTAL_W-1:0] idx_ext;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == S_IDLE) && out_free);
   assign accept = req_valid && !req_stall;
   assign next_pos = {1'b0, pick_pos_ff} + 11'd1;
   assign fill_next = fill_cnt_ff + 11'd1;
   assign idx_ext = {1'b0, req_pick_index};

   always_comb begin
      state_in = state_ff;
      prev_total_in = prev_total_ff;
      act_total_in = act_total_ff;
      act_select_in = act_select_ff;
      cur_pos_in = cur_pos_ff;
      sel_active_in = sel_active_ff;
      fill_cnt_in = fill_cnt_ff;
      pick_idx_in = pick_idx_ff;
      pick_pos_in = pick_pos_ff;
      load = 1'b0;
      rsp_value_in = rsp_value_ff;
      rsp_pos_in = rsp_pos_ff;
      rsp_last_in = rsp_last_ff;
      rsp_status_in = rsp_status_ff;
      mem_req = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_value_in = '0;
               rsp_pos_in = '0;
               rsp_last_in = 1'b0;
               if (req_type == REQ_START) begin
                  load = 1'b1;
                  if ({6'd0, req_total} > CapLimit) begin
                     rsp_status_in = ST_CAP_OVER;
                  end else if (req_select_count > req_total) begin
                     rsp_status_in = ST_SEL_OVER;
                  end else begin
                     rsp_status_in = ST_OK;
                     rsp_last_in = (req_select_count == '0);
                     if (req_total != prev_total_ff) begin
                        prev_total_in = req_total;
                        fill_cnt_in = '0;
                        if (req_total != '0) begin
                           state_in = S_FILL;
                        end
                     end
                     act_total_in = req_total;
                     act_select_in = req_select_count;
                     cur_pos_in = '0;
                     sel_active_in = (req_select_count != '0);
                  end
               end else if (!sel_active_ff) begin
                  load = 1'b1;
                  rsp_status_in = ST_IDLE;
               end else if (idx_ext < cur_pos_ff || idx_ext >= act_total_ff) begin
                  load = 1'b1;
                  rsp_status_in = ST_BAD_INDEX;
                  rsp_pos_in = cur_pos_ff[IDX_W-1:0];
               end else begin
                  mem_req.rd_en = 1'b1;
                  mem_req.rd_addr_a = idx_ext;
                  mem_req.rd_addr_b = cur_pos_ff;
                  pick_idx_in = req_pick_index;
                  pick_pos_in = cur_pos_ff[IDX_W-1:0];
                  state_in = S_SWAP_A;
               end
            end
         end
         S_FILL: begin
            mem_req.wr_en = 1'b1;
            mem_req.wr_addr = fill_cnt_ff;
            mem_req.wr_data = fill_cnt_ff[VAL_W-1:0];
            fill_cnt_in = fill_next;
            if (fill_next == act_total_ff) begin
               state_in = S_IDLE;
            end
         end
         S_SWAP_A: begin
            if (out_free) begin
               mem_req.wr_en = 1'b1;
               mem_req.wr_addr = {1'b0, pick_pos_ff};
               mem_req.wr_data = rd_data_a;
               load = 1'b1;
               rsp_value_in = rd_data_a;
               rsp_pos_in = pick_pos_ff;
               rsp_last_in = (next_pos >= act_select_ff);
               rsp_status_in = ST_OK;
               cur_pos_in = next_pos;
               if (next_pos >= act_select_ff) begin
                  sel_active_in = 1'b0;
               end
               state_in = S_SWAP_B;
            end
         end
         S_SWAP_B: begin
            mem_req.wr_en = 1'b1;
            mem_req.wr_addr = {1'b0, pick_idx_ff};
            mem_req.wr_data = rd_data_b;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         prev_total_ff <= '0;
         act_total_ff <= '0;
         act_select_ff <= '0;
         cur_pos_ff <= '0;
         sel_active_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         prev_total_ff <= prev_total_in;
         act_total_ff <= act_total_in;
         act_select_ff <= act_select_in;
         cur_pos_ff <= cur_pos_in;
         sel_active_ff <= sel_active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      fill_cnt_ff <= fill_cnt_in;
      pick_idx_ff <= pick_idx_in;
      pick_pos_ff <= pick_pos_in;
      rsp_value_ff <= rsp_value_in;
      rsp_pos_ff <= rsp_pos_in;
      rsp_last_ff <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_picked_value = rsp_value_ff;
   assign rsp_position = rsp_pos_ff;
   assign rsp_last = rsp_last_ff;
   assign rsp_status = rsp_status_ff;

   `PSEL_ASSERT(swap_follows, clock, reset, (state_ff == S_SWAP_A && out_free) |=> (state_ff == S_SWAP_B), "second swap write skipped")
   `PSEL_ASSERT(fill_in_range, clock, reset, (state_ff == S_FILL) |-> (fill_cnt_ff < act_total_ff), "refill walks past total")
   `PSEL_ASSERT(pos_below_select, clock, reset, sel_active_ff |-> (cur_pos_ff < act_select_ff), "active selection past its count")
   `PSEL_ASSERT_ALWAYS(select_within_total, clock, reset, act_select_ff <= act_total_ff, "selection count exceeds total")

endmodule

// File: sv/partial_shuffle_selector_unit.sv
// Top level of the partial shuffle selector
// Results: start, error and bad-index results are registered in the cycle after acceptance;
//   a valid pick result is registered in S_SWAP_A once the output is free, after the store read.
// Pick: two reads in the accepting cycle, then one write per cycle on the store port (S_SWAP_A, S_SWAP_B);
//   a start that changes the total to a nonzero value runs the identity refill walk in S_FILL.
// Reset: synchronous; clears totals, position and active flag; the store is not cleared.
module partial_shuffle_selector_unit
   import psel_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic req_type,
   input  logic [TOTAL_W-1:0] req_total,
   input  logic [TOTAL_W-1:0] req_select_count,
   input  logic [IDX_W-1:0] req_pick_index,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [VAL_W-1:0] rsp_picked_value,
   output logic [IDX_W-1:0] rsp_position,
   output logic rsp_last,
   output logic [STATUS_W-1:0] rsp_status
);

   localparam int Depth = (CAPACITY < DEPTH_MAX) ? CAPACITY : DEPTH_MAX;
   localparam int AddrW = $clog2(Depth);

   psel_mem_req_type mem_req;
   logic [VAL_W-1:0] rd_data_a;
   logic [VAL_W-1:0] rd_data_b;

   psel_ctrl #(
      .CAPACITY(CAPACITY)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_type(req_type),
      .req_total(req_total),
      .req_select_count(req_select_count),
      .req_pick_index(req_pick_index),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_picked_value(rsp_picked_value),
      .rsp_position(rsp_position),
      .rsp_last(rsp_last),
      .rsp_status(rsp_status),
      .mem_req(mem_req),
      .rd_data_a(rd_data_a),
      .rd_data_b(rd_data_b)
   );

   psel_store #(
      .DEPTH(Depth),
      .ADDR_W(AddrW)
   ) u_store (
      .clock(clock),
      .mem_req(mem_req),
      .rd_data_a(rd_data_a),
      .rd_data_b(rd_data_b)
   );

endmodule
